// File: rtl/core/gpibq_pkg.sv
// gpibq_pkg: shared types, codes and the control byte decoder for the
// bus listener print queue. No dependencies.
package gpibq_pkg;

  // item kinds carried on the input tuser
  localparam logic [1:0] CMD_CONTROL = 2'd0;
  localparam logic [1:0] CMD_DATA    = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // fixed field widths
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ENTRY_W = BYTE_W + 1;
  localparam int unsigned DELAY_W = 3;

  // bus command bytes, parity stripped
  localparam logic [6:0] UNLISTEN_CODE = 7'h3F;
  localparam logic [6:0] UNTALK_CODE   = 7'h5F;
  localparam logic [1:0] LISTEN_GROUP  = 2'b01;
  localparam logic [1:0] TALK_GROUP    = 2'b10;

  // control byte events
  typedef enum logic [2:0] {
    EV_MY_LISTEN,
    EV_MY_TALK,
    EV_UNLISTEN,
    EV_UNTALK,
    EV_OTHER
  } ctrl_ev_e;

  // first match wins: my listen, my talk, unlisten, untalk, anything else
  function automatic ctrl_ev_e decode_ctrl(input logic [BYTE_W-1:0] raw,
                                           input logic [ADDR_W-1:0] addr);
    logic [6:0] c;
    ctrl_ev_e   ev;
    c = raw[6:0];
    if (c == {LISTEN_GROUP, addr}) begin
      ev = EV_MY_LISTEN;
    end else if (c == {TALK_GROUP, addr}) begin
      ev = EV_MY_TALK;
    end else if (c == UNLISTEN_CODE) begin
      ev = EV_UNLISTEN;
    end else if (c == UNTALK_CODE) begin
      ev = EV_UNTALK;
    end else begin
      ev = EV_OTHER;
    end
    return ev;
  endfunction

endpackage

// File: rtl/core/gpib_listener_print_queue.sv
// An accepted transaction's result reaches the master side in the next cycle.
// Throughput: one transaction per cycle; the queue ram takes one push or one
// pop read per cycle and the head entry arrives through its registered read port.
// Input is taken whenever the result register is empty or being drained.
// Reset: flags and pointers clear, bus address 1, head delay reloads; the ram
// is not cleared, only entries between head and tail are ever read.
module gpib_listener_print_queue #(
  parameter int unsigned QUEUE_DEPTH    = 512,
  parameter int unsigned TRANSFER_DELAY = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gpibq_pkg::ADDR_W-1:0] cfg_data_i,   // bus_address
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0] s_axis_tuser,   // [1:0] command
  input  logic       s_axis_tlast,   // end_flag
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] print_byte
  output logic [1:0] m_axis_tuser,   // [0] accepted, [1] print_valid
  output logic       m_axis_tlast    // print_end
);
  import gpibq_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]   LAST_POS   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [DELAY_W-1:0] DELAY_INIT = DELAY_W'(TRANSFER_DELAY);

  logic [ADDR_W-1:0]  bus_addr_q;
  logic               listen_q, listen_d;
  logic               talk_q, talk_d;
  logic               untalk_q, untalk_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic               out_valid_q, out_valid_d;
  logic               acc_q, pv_q;

  logic               accept;
  logic               is_ctrl, is_data, is_tick;
  logic [PTR_W-1:0]   tail_nxt, head_nxt;
  logic               q_full, q_empty;
  logic               push, refuse, pop, dec;
  ctrl_ev_e           ev;
  logic [ENTRY_W-1:0] rd_entry;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_addr_q <= ADDR_W'(1);
    end else if (cfg_valid_i) begin
      bus_addr_q <= cfg_data_i;
    end
  end

  // input transaction and kind
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_ctrl       = (s_axis_tuser == CMD_CONTROL);
  assign is_data       = (s_axis_tuser == CMD_DATA);
  assign is_tick       = (s_axis_tuser == CMD_TICK);

  // queue pointer arithmetic
  assign tail_nxt = (tail_q == LAST_POS) ? '0 : tail_q + PTR_W'(1);
  assign head_nxt = (head_q == LAST_POS) ? '0 : head_q + PTR_W'(1);
  assign q_full   = (tail_nxt == head_q);
  assign q_empty  = (head_q == tail_q);

  // queue actions
  assign push   = accept && is_data && (listen_q || talk_q) && !q_full;
  assign refuse = accept && is_data && (listen_q || talk_q) && q_full;
  assign pop    = accept && is_tick && !q_empty && (delay_q == '0);
  assign dec    = accept && is_tick && !q_empty && (delay_q != '0);

  assign ev = decode_ctrl(s_axis_tdata, bus_addr_q);

  // addressing flags
  always_comb begin
    listen_d = listen_q;
    talk_d   = talk_q;
    untalk_d = untalk_q;
    if (accept && is_ctrl) begin
      untalk_d = 1'b0;
      case (ev)
        EV_MY_LISTEN: listen_d = 1'b1;
        EV_MY_TALK:   talk_d   = 1'b1;
        EV_UNLISTEN:  listen_d = 1'b0;
        EV_UNTALK: begin
          talk_d   = 1'b0;
          untalk_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // pointers and head delay; every entry starts with the same delay, so only
  // the head's remaining count is kept
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    delay_d = delay_q;
    if (push) begin
      tail_d = tail_nxt;
    end
    if (pop) begin
      head_d  = head_nxt;
      delay_d = DELAY_INIT;
    end else if (dec) begin
      delay_d = delay_q - DELAY_W'(1);
    end
  end

  // result register control
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q    <= 1'b0;
      talk_q      <= 1'b0;
      untalk_q    <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      delay_q     <= DELAY_INIT;
      out_valid_q <= 1'b0;
    end else begin
      listen_q    <= listen_d;
      talk_q      <= talk_d;
      untalk_q    <= untalk_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      delay_q     <= delay_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= !refuse;
      pv_q  <= pop && listen_q;
    end
  end

  // queue storage; the popped entry lands in the ram read register
  gpibq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (tail_q),
    .wdata_i ({s_axis_tlast, s_axis_tdata}),
    .re_i    (pop),
    .raddr_i (head_q),
    .rdata_o (rd_entry)
  );

  // output stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {pv_q, acc_q};
  assign m_axis_tdata  = pv_q ? rd_entry[BYTE_W-1:0] : '0;
  assign m_axis_tlast  = pv_q && rd_entry[BYTE_W];

  // checks
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (head_q != tail_q))
    else $error("queue empty right after a push");

  a_pop_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != $past(head_q)) |-> ($past(delay_q) == '0))
    else $error("head advanced before its delay ran out");

  a_print_listening: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (listen_q && m_axis_tuser[0]))
    else $error("print result while not listening");

  a_untalk_clears_talk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    untalk_q |-> !talk_q)
    else $error("untalk seen while still talking");

endmodule

// File: rtl/core/gpibq_ram.sv
// gpibq_ram: simple dual port queue storage, one write and one read port,
// read data registered. Depends on nothing.
module gpibq_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
